>>> sv/bounded_deque_with_remove_by_value_macros.svh
// Assertion macros for the bounded deque.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_BY_VALUE_MACROS_SVH

`define BDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define BDQ_ASSERT_NEVER(label, expr, msg) \
	`BDQ_ASSERT(label, !(expr), msg)

`endif

>>> sv/bdq_pkg.sv
// Shared types and constants for the bounded deque.
package bdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int IN_W      = ((ACT_W + DATA_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_REMOVE     = 3'd4,
		ACT_DUMP       = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_PUSH_BACK  = 3'd2,
		CELL_POP_FRONT  = 3'd3,
		CELL_REMOVE     = 3'd4,
		CELL_ROTATE     = 3'd5
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [DATA_W-1:0] data;
	} cell_ctrl_t;

endpackage

>>> sv/bdq_cell.sv
// One storage cell of the deque chain: holds one entry and trades it with its neighbors.
module bdq_cell #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                               clk,
	input  bdq_pkg::cell_ctrl_t                ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]         count,
	input  logic [bdq_pkg::DATA_W-1:0]         left_val,
	input  logic [bdq_pkg::DATA_W-1:0]         right_val,
	input  logic                               seen_in,
	output logic [bdq_pkg::DATA_W-1:0]         val,
	output logic                               seen_out
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [bdq_pkg::DATA_W-1:0] val_q;
	logic [bdq_pkg::DATA_W-1:0] val_d;
	logic                       occupied;
	logic                       match;
	logic                       at_back;
	logic                       at_tail;

	assign occupied = count > CW'(IDX);
	assign match    = occupied && (val_q == ctrl.data);
	assign seen_out = seen_in | match;
	assign at_tail  = count == CW'(IDX);
	assign at_back  = count == CW'(IDX + 1);
	assign val      = val_q;

	always_comb begin
		val_d = val_q;
		unique case (ctrl.cmd)
			bdq_pkg::CELL_HOLD:       val_d = val_q;
			bdq_pkg::CELL_PUSH_FRONT: val_d = (IDX == 0) ? ctrl.data : left_val;
			bdq_pkg::CELL_PUSH_BACK:  val_d = at_tail ? ctrl.data : val_q;
			bdq_pkg::CELL_POP_FRONT:  val_d = right_val;
			bdq_pkg::CELL_REMOVE:     val_d = seen_out ? right_val : val_q;
			bdq_pkg::CELL_ROTATE:     val_d = at_back ? ctrl.data : right_val;
			default:                  val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

>>> sv/bounded_deque_with_remove_by_value.sv
// Bounded deque with remove-by-value: top level with control and output register.
//
// Input channel s_*: one word per action (push front, push back, pop front,
// pop back, remove first matching value, dump). Output channel m_*: result
// words with status, occupancy after the action, entry value and tlast.
// Entries sit in a chain of DEPTH cells, front in cell 0. Push front, pop
// front and remove (from the match on) shift the chain, push back fills
// the tail cell and pop back only lowers occupancy, all in the cycle the
// word is taken; removal compares all occupied cells with the value in
// parallel. The first result is registered and appears in the cycle after
// the word is taken. Throughput: one action word per cycle while results
// drain and no dump is under way; a dump of N entries holds off new words
// for N results, rotating the chain once per result so its order is
// restored after the last one. Reset empties the deque; entry contents are
// not cleared. On a stall the output word holds and s_tready drops until taken.
module bounded_deque_with_remove_by_value #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                                                         clk,
	input  logic                                                         arst_n,
	input  logic                                                         s_tvalid,
	output logic                                                         s_tready,
	// [2:0] action, [34:3] item_in, rest zero
	input  logic [bdq_pkg::IN_W-1:0]                                     s_tdata,
	output logic                                                         m_tvalid,
	input  logic                                                         m_tready,
	// [1:0] status, then occupancy, then item_out, rest zero
	output logic [((bdq_pkg::STAT_W+$clog2(DEPTH+1)+bdq_pkg::DATA_W+7)/8)*8-1:0] m_tdata,
	output logic                                                         m_tlast
);

	`include "bounded_deque_with_remove_by_value_macros.svh"

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int OUT_W = ((bdq_pkg::STAT_W + CW + bdq_pkg::DATA_W + 7) / 8) * 8;

	logic [bdq_pkg::DATA_W-1:0] vals [DEPTH];
	logic [bdq_pkg::DATA_W-1:0] lefts [DEPTH];
	logic [bdq_pkg::DATA_W-1:0] rights [DEPTH];
	logic [DEPTH:0]             seen;

	bdq_pkg::state_t     state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       remain_q, remain_d;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;
	logic                m_tlast_q;

	bdq_pkg::cell_ctrl_t       ctrl;
	bdq_pkg::action_t          action;
	logic [bdq_pkg::DATA_W-1:0] item_in;
	logic                      out_free;
	logic                      acc;
	logic                      full;
	logic                      empty;
	logic                      found;
	logic                      ld;
	bdq_pkg::status_t          o_status;
	logic [bdq_pkg::DATA_W-1:0] o_item;
	logic                      o_last;

	assign action   = bdq_pkg::action_t'(s_tdata[bdq_pkg::ACT_W-1:0]);
	assign item_in  = s_tdata[bdq_pkg::ACT_W+bdq_pkg::DATA_W-1:bdq_pkg::ACT_W];
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == bdq_pkg::ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign found    = seen[DEPTH];
	assign seen[0]  = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign lefts[gi] = '0;
			end else begin : g_mid_l
				assign lefts[gi] = vals[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rights[gi] = '0;
			end else begin : g_mid_r
				assign rights[gi] = vals[gi+1];
			end
			bdq_cell #(
				.DEPTH(DEPTH),
				.IDX  (gi)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.count    (count_q),
				.left_val (lefts[gi]),
				.right_val(rights[gi]),
				.seen_in  (seen[gi]),
				.val      (vals[gi]),
				.seen_out (seen[gi+1])
			);
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		remain_d  = remain_q;
		ctrl.cmd  = bdq_pkg::CELL_HOLD;
		ctrl.data = item_in;
		ld        = 1'b0;
		o_status  = bdq_pkg::STAT_OK;
		o_item    = '0;
		o_last    = 1'b1;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (acc) begin
					ld = 1'b1;
					unique case (action)
						bdq_pkg::ACT_PUSH_FRONT: begin
							if (full) begin
								o_status = bdq_pkg::STAT_FULL;
							end else begin
								ctrl.cmd = bdq_pkg::CELL_PUSH_FRONT;
								count_d  = count_q + 1'b1;
							end
						end
						bdq_pkg::ACT_PUSH_BACK: begin
							if (full) begin
								o_status = bdq_pkg::STAT_FULL;
							end else begin
								ctrl.cmd = bdq_pkg::CELL_PUSH_BACK;
								count_d  = count_q + 1'b1;
							end
						end
						bdq_pkg::ACT_POP_FRONT: begin
							if (empty) begin
								o_status = bdq_pkg::STAT_EMPTY;
							end else begin
								ctrl.cmd = bdq_pkg::CELL_POP_FRONT;
								count_d  = count_q - 1'b1;
							end
						end
						bdq_pkg::ACT_POP_BACK: begin
							if (empty) begin
								o_status = bdq_pkg::STAT_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						bdq_pkg::ACT_REMOVE: begin
							ctrl.cmd = bdq_pkg::CELL_REMOVE;
							if (empty) begin
								o_status = bdq_pkg::STAT_EMPTY;
							end else if (found) begin
								count_d = count_q - 1'b1;
							end else begin
								o_status = bdq_pkg::STAT_NOTFOUND;
							end
						end
						bdq_pkg::ACT_DUMP: begin
							if (empty) begin
								o_status = bdq_pkg::STAT_EMPTY;
							end else begin
								ctrl.cmd  = bdq_pkg::CELL_ROTATE;
								ctrl.data = vals[0];
								o_item    = vals[0];
								o_last    = count_q == CW'(1);
								if (count_q != CW'(1)) begin
									state_d  = bdq_pkg::ST_DUMP;
									remain_d = count_q - 1'b1;
								end
							end
						end
						default: begin
							o_status = bdq_pkg::STAT_OK;
						end
					endcase
				end
			end
			bdq_pkg::ST_DUMP: begin
				if (out_free) begin
					ld        = 1'b1;
					ctrl.cmd  = bdq_pkg::CELL_ROTATE;
					ctrl.data = vals[0];
					o_item    = vals[0];
					o_last    = remain_q == CW'(1);
					remain_d  = remain_q - 1'b1;
					if (remain_q == CW'(1)) begin
						state_d = bdq_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bdq_pkg::ST_IDLE;
			count_q    <= '0;
			remain_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_tdata_q <= OUT_W'({o_item, count_d, o_status});
			m_tlast_q <= o_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`BDQ_ASSERT_NEVER(a_count_bound, count_q > CW'(DEPTH), "occupancy above depth")
	`BDQ_ASSERT(a_dump_remain, (state_q == bdq_pkg::ST_DUMP) |-> (remain_q != '0 && remain_q < count_q), "dump counter out of range")
	`BDQ_ASSERT(a_push_grows, (acc && action == bdq_pkg::ACT_PUSH_BACK && !full) |=> (count_q == $past(count_q) + 1'b1), "push did not grow occupancy")
	`BDQ_ASSERT(a_dump_last, (m_tvalid && m_tready && state_q == bdq_pkg::ST_DUMP && remain_q != '0) |-> !m_tlast, "tlast before dump end")

endmodule

>>> tb/bounded_deque_with_remove_by_value_test.sv
// Self-checking testbench for the bounded deque with remove-by-value.
module bounded_deque_with_remove_by_value_test;
	import bdq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int OCC_W          = $clog2(DEPTH + 1);
	localparam int OUT_W          = ((STAT_W + OCC_W + DATA_W + 7) / 8) * 8;
	localparam int STALL_MAX      = 19;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 150;
	localparam int PHASE_LEN      = 25;
	localparam int REPORT_MAX     = 10;
	localparam logic [ACT_W-1:0] ACT_UNDEF_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNDEF_B = 3'd7;

	typedef struct packed {
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
		logic [DATA_W-1:0] item;
		logic              last;
	} result_t;

	class deque_mirror;
		logic [DATA_W-1:0] held[$];
		result_t           pending_results[$];
		int                mismatches;

		function void add_result(status_t st, logic [DATA_W-1:0] item, logic last);
			result_t r;
			r.status    = st;
			r.occupancy = OCC_W'(held.size());
			r.item      = item;
			r.last      = last;
			pending_results.push_back(r);
		endfunction

		function void apply_action(logic [ACT_W-1:0] act, logic [DATA_W-1:0] value);
			status_t st;
			int      pos;
			st  = STAT_OK;
			pos = -1;
			case (act)
				ACT_PUSH_FRONT: begin
					if (held.size() >= DEPTH) st = STAT_FULL;
					else held.push_front(value);
				end
				ACT_PUSH_BACK: begin
					if (held.size() >= DEPTH) st = STAT_FULL;
					else held.push_back(value);
				end
				ACT_POP_FRONT: begin
					if (held.size() == 0) st = STAT_EMPTY;
					else void'(held.pop_front());
				end
				ACT_POP_BACK: begin
					if (held.size() == 0) st = STAT_EMPTY;
					else void'(held.pop_back());
				end
				ACT_REMOVE: begin
					if (held.size() == 0) begin
						st = STAT_EMPTY;
					end else begin
						foreach (held[i])
							if (pos < 0 && held[i] == value) pos = i;
						if (pos < 0) st = STAT_NOTFOUND;
						else held.delete(pos);
					end
				end
				ACT_DUMP: begin
					if (held.size() == 0) add_result(STAT_EMPTY, '0, 1'b1);
					else foreach (held[i]) add_result(STAT_OK, held[i], i == held.size() - 1);
					return;
				end
				default: ;
			endcase
			add_result(st, '0, 1'b1);
		endfunction

		function void complain(string what);
			mismatches++;
			if (mismatches <= REPORT_MAX) $display("%s", what);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				complain($sformatf("unexpected word: status %0d occupancy %0d item %h last %b",
					got.status, got.occupancy, got.item, got.last));
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.occupancy !== want.occupancy ||
					got.item !== want.item || got.last !== want.last)
				complain($sformatf({"mismatch: expected status %0d occupancy %0d item %h last %b,",
					" got status %0d occupancy %0d item %h last %b"},
					want.status, want.occupancy, want.item, want.last,
					got.status, got.occupancy, got.item, got.last));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;

	deque_mirror       mirror = new();
	bit                no_idle;
	int                ready_hold;
	int                quiet_cycles;
	logic [DATA_W-1:0] boundary_values [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0};

	bounded_deque_with_remove_by_value dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_action(logic [ACT_W-1:0] act, logic [DATA_W-1:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - ACT_W - DATA_W){1'b0}}, value, act};
		do @(posedge clk); while (!s_tready);
		mirror.apply_action(act, value);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (mirror.pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [ACT_W-1:0] pick_action(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return r[0] ? ACT_UNDEF_A : ACT_UNDEF_B;
		if (r < 11) return ACT_DUMP;
		if (r < 25) return ACT_REMOVE;
		if (r < (filling ? 80 : 45)) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
		return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value(logic [ACT_W-1:0] act);
		if (act == ACT_REMOVE && mirror.held.size() > 0 && $urandom_range(0, 2) != 0)
			return mirror.held[$urandom_range(0, mirror.held.size() - 1)];
		case ($urandom_range(0, 3))
			0: return DATA_W'($urandom_range(0, 3));
			1: return boundary_values[$urandom_range(0, 3)];
			default: return $urandom;
		endcase
	endfunction

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				m_tready <= 1'b0;
				ready_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				mirror.check_result('{status_t'(m_tdata[STAT_W-1:0]),
					m_tdata[STAT_W +: OCC_W], m_tdata[STAT_W + OCC_W +: DATA_W], m_tlast});
				ready_hold = no_idle ? 0 : $urandom_range(0, STALL_MAX);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [ACT_W-1:0] act;
		bit               filling;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		no_idle  = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_action(ACT_DUMP, '0);
		send_action(ACT_POP_FRONT, '0);
		send_action(ACT_POP_BACK, '0);
		send_action(ACT_REMOVE, 32'h7fff_ffff);
		send_action(ACT_UNDEF_A, 32'hffff_ffff);
		for (int i = 0; i < DEPTH; i++)
			send_action(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
				(i < 4) ? boundary_values[i] : (i % 5 == 0) ? 32'h7fff_ffff : $urandom);
		send_action(ACT_PUSH_FRONT, 32'h1234_5678);
		send_action(ACT_PUSH_BACK, 32'h8765_4321);
		send_action(ACT_DUMP, '0);
		send_action(ACT_REMOVE, 32'h7fff_fffe);
		send_action(ACT_REMOVE, 32'h7fff_ffff);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				filling = ((n / PHASE_LEN) % 2) == 0;
				no_idle = $urandom_range(0, 3) == 0;
			end
			if (n == RANDOM_ITEMS / 2) wait_drained();
			act = pick_action(filling);
			send_action(act, pick_value(act));
		end
		wait_drained();
		repeat (20) @(negedge clk);

		if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bounded_deque_with_remove_by_value.sv
tb/bounded_deque_with_remove_by_value_test.sv
